// ===== sv/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, character codes and helpers for the size suffix parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int COPY_LIMIT_DEF = 32;
    localparam int POS_W          = 6;
    localparam int ACC_W          = 64;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_B     = 8'd66;
    localparam logic [7:0] CH_G     = 8'd71;
    localparam logic [7:0] CH_K     = 8'd75;
    localparam logic [7:0] CH_M     = 8'd77;

    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_CLOSED = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        UNIT_B = 2'd0,
        UNIT_K = 2'd1,
        UNIT_M = 2'd2,
        UNIT_G = 2'd3
    } t_unit;

    // number summary seen by the finalize stage on the last character
    typedef struct packed {
        logic              short_path;
        logic              num_bad;
        logic              negate;
        logic [ACC_W-1:0]  acc;
    } t_scan_res;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== sv/ssp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_in_if / ssp_out_if
// Valid/ready channels for path characters in and size results out.
// ----------------------------------------------------------------------------
interface ssp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ssp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] size_bytes;
    logic [1:0]  status;

    modport source (output valid, output size_bytes, output status, input ready);
    modport sink   (input valid, input size_bytes, input status, output ready);
endinterface

// ===== sv/size_suffix_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_suffix_parser
// Parses a path such as /512K one character per request into a byte size.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result output is not stalled, no gaps between paths.
// Pipeline: the result is registered after the last character is taken, passing through
//          the input register, scan/sign stage and scaling into the result register.
// Reset: synchronous active-low i_rst_n empties the pipeline and returns the
//        scanner to the start of a path.
module size_suffix_parser
    import ssp_pkg::*;
#(
    parameter int COPY_LIMIT = COPY_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssp_in_if.sink    i_in,
    ssp_out_if.source o_out
);

    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;
    logic       adv;
    t_scan_res  scan_res;

    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_s1_char <= i_in.char_code;
            r_s1_last <= i_in.last;
        end
    end

    ssp_scanner #(
        .COPY_LIMIT (COPY_LIMIT)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv && r_s1_valid),
        .i_char  (r_s1_char),
        .i_last  (r_s1_last),
        .o_res   (scan_res)
    );

    ssp_finalize u_finalize (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (r_s1_valid && r_s1_last),
        .i_unit_char (r_s1_char),
        .i_res       (scan_res),
        .o_adv       (adv),
        .o_out       (o_out)
    );

endmodule

// ===== sv/ssp_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_scanner
// Per-character decimal scan state: whitespace, sign, digits, window close.
// ----------------------------------------------------------------------------
module ssp_scanner
    import ssp_pkg::*;
#(
    parameter int COPY_LIMIT = COPY_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_scan_res  o_res
);

    localparam logic [POS_W-1:0] WIN_END = POS_W'(COPY_LIMIT - 2);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic             r_neg, n_neg;
    logic             r_mal, n_mal;

    logic [3:0]       digit;
    logic [ACC_W+3:0] prod;
    logic             in_window;

    assign digit     = 4'(i_char - CH_ZERO);
    assign prod      = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {64'd0, digit};
    assign in_window = (r_pos != '0) && (r_pos <= WIN_END);

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_neg   = r_neg;
        n_mal   = r_mal;
        if (i_en) begin
            if (i_last) begin
                n_pos   = '0;
                n_phase = PH_SPACE;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_neg   = 1'b0;
                n_mal   = 1'b0;
            end else begin
                if (in_window) begin
                    unique case (r_phase)
                        PH_SPACE: begin
                            if (is_space(i_char)) begin
                                n_phase = PH_SPACE;
                            end else if (i_char == CH_PLUS) begin
                                n_phase = PH_SIGN;
                            end else if (i_char == CH_MINUS) begin
                                n_phase = PH_SIGN;
                                n_neg   = 1'b1;
                                if (r_pos == POS_W'(1)) n_mal = 1'b1;
                            end else if (is_digit(i_char)) begin
                                n_acc   = {60'd0, digit};
                                n_phase = PH_DIGITS;
                            end else begin
                                n_mal   = 1'b1;
                                n_phase = PH_CLOSED;
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit(i_char)) begin
                                n_acc   = {60'd0, digit};
                                n_phase = PH_DIGITS;
                            end else begin
                                n_mal   = 1'b1;
                                n_phase = PH_CLOSED;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit(i_char)) begin
                                n_acc = prod[ACC_W-1:0];
                                if (prod[ACC_W+3:ACC_W] != '0) n_ovf = 1'b1;
                            end else begin
                                n_mal   = 1'b1;
                                n_phase = PH_CLOSED;
                            end
                        end
                        PH_CLOSED: n_phase = PH_CLOSED;
                        default:   n_phase = PH_CLOSED;
                    endcase
                    if (r_pos == WIN_END) begin
                        if (n_phase == PH_SPACE || n_phase == PH_SIGN) n_mal = 1'b1;
                        n_phase = PH_CLOSED;
                    end
                end
                if (r_pos != POS_MAX) n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_neg   <= 1'b0;
            r_mal   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_neg   <= n_neg;
            r_mal   <= n_mal;
        end
    end

    always_comb begin
        o_res.short_path = (r_pos < POS_W'(2));
        o_res.num_bad    = r_mal || r_ovf || (r_phase == PH_SPACE) || (r_phase == PH_SIGN);
        o_res.negate     = r_neg;
        o_res.acc        = r_acc;
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_pos == '0 && r_phase == PH_SPACE && !r_mal && !r_ovf))
        else $error("scan state not cleared after last character");

    a_closed_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED && !(i_en && i_last)) |=> $stable(r_acc))
        else $error("accumulator moved after number window closed");

endmodule

// ===== sv/ssp_finalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_finalize
// Sign fix and unit decode, then unit scaling into the result register.
// ----------------------------------------------------------------------------
module ssp_finalize
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_unit_char,
    input  t_scan_res        i_res,
    output logic             o_adv,
    ssp_out_if.source        o_out
);

    logic             r_s2_valid;
    logic             r_s2_bad;
    t_unit            r_s2_unit;
    logic [ACC_W-1:0] r_s2_v;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [ACC_W-1:0] r_out_size;

    t_unit            unit;
    logic             unit_bad;
    logic             over;
    logic [ACC_W-1:0] scaled;
    t_status          n_status;
    logic [ACC_W-1:0] n_size;

    assign o_adv = !r_out_valid || o_out.ready;

    always_comb begin
        unit     = UNIT_B;
        unit_bad = 1'b0;
        unique case (i_unit_char)
            CH_B:    unit = UNIT_B;
            CH_K:    unit = UNIT_K;
            CH_M:    unit = UNIT_M;
            CH_G:    unit = UNIT_G;
            default: unit_bad = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_adv) begin
            r_s2_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_take) begin
            r_s2_bad  <= i_res.short_path || i_res.num_bad || unit_bad;
            r_s2_unit <= unit;
            r_s2_v    <= i_res.negate ? (ACC_W'(0) - i_res.acc) : i_res.acc;
        end
    end

    always_comb begin
        unique case (r_s2_unit)
            UNIT_B: begin
                over   = 1'b0;
                scaled = r_s2_v;
            end
            UNIT_K: begin
                over   = |r_s2_v[63:54];
                scaled = {r_s2_v[53:0], 10'd0};
            end
            UNIT_M: begin
                over   = |r_s2_v[63:44];
                scaled = {r_s2_v[43:0], 20'd0};
            end
            UNIT_G: begin
                over   = |r_s2_v[63:34];
                scaled = {r_s2_v[33:0], 30'd0};
            end
            default: begin
                over   = 1'b0;
                scaled = r_s2_v;
            end
        endcase
    end

    always_comb begin
        priority if (r_s2_bad) begin
            n_status = ST_NOT_FOUND;
            n_size   = '0;
        end else if (over) begin
            n_status = ST_TOO_LARGE;
            n_size   = '0;
        end else begin
            n_status = ST_OK;
            n_size   = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_s2_valid) begin
            r_out_status <= n_status;
            r_out_size   <= n_size;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.size_bytes = r_out_size;

    a_err_zero_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_size == '0))
        else $error("nonzero size with error status");

    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("result appeared without a stage 2 request");

    a_bad_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && r_s2_valid && r_s2_bad) |=> (r_out_status == ST_NOT_FOUND))
        else $error("rejected path did not report not-found");

endmodule
